@@ hdl/drg_pkg.sv @@
// shared constants, types and the sine table for the distance rolloff gain block
package drg_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int DIST_W     = 24;
   localparam int GAIN_W     = 16;
   localparam int POS_W      = 24;
   localparam int DIFF_W     = POS_W + 1;
   localparam int RAD_W      = 2 * DIFF_W;
   localparam int ROOT_W     = DIFF_W;
   localparam int NUM_W      = GAIN_W + DIST_W + 2;
   localparam int DEN_W      = DIST_W + 1;
   localparam int QUO_W      = GAIN_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAIN_W:0]   UNITY    = 17'd32768;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROLLOFF_ON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS     = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT,
      ST_LOOK_FIRST,
      ST_LOOK_LAST,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_PREP,
      ST_PROD,
      ST_DIV_GO,
      ST_DIV,
      ST_MUL1,
      ST_MUL2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

   localparam logic [15:0] SINE_TAB [33] = '{
      16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
      16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
      16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
      16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
      16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
      16'd32610, 16'd32729, 16'd32768
   };

   // sin(x/65536 * pi/2) in q1.15, linear between table points
   function automatic logic [GAIN_W-1:0] quarter_sine(input logic [16:0] x);
      logic [5:0]  idx;
      logic [5:0]  idx_nx;
      logic [10:0] frac;
      logic [15:0] a;
      logic [15:0] b;
      logic [26:0] prod;
      logic [15:0] res;
      idx    = x[16:11];
      idx_nx = idx + 6'd1;
      frac   = x[10:0];
      a      = SINE_TAB[idx[4:0]];
      b      = SINE_TAB[idx_nx];
      prod   = 27'(b - a) * 27'(frac) + 27'd1024;
      res    = a + 16'(prod >> 11);
      if (idx[5]) begin
         res = UNITY[15:0];
      end
      return res;
   endfunction

   function automatic logic [GAIN_W-1:0] sat_unity(input logic [GAIN_W:0] v);
      return (v > UNITY) ? UNITY[GAIN_W-1:0] : v[GAIN_W-1:0];
   endfunction

endpackage

@@ hdl/drg_sqrt.sv @@
// iterative integer square root, two radicand bits per cycle
module drg_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [drg_pkg::RAD_W-1:0]   radicand,
   output logic [drg_pkg::ROOT_W-1:0]  root,
   output logic                        done
);
   import drg_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic              done_ff;

   logic [REM_W-1:0]  rem_in;
   logic [REM_W-1:0]  trial;
   logic [ROOT_W-1:0] root_in;

   always_comb begin
      rem_in  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      root_in = {root_ff[ROOT_W-2:0], 1'b0};
      if (rem_in >= trial) begin
         rem_in  = rem_in - trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

@@ hdl/drg_div.sv @@
// restoring divider, one quotient bit per cycle
module drg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [drg_pkg::NUM_W-1:0]  numer,
   input  logic [drg_pkg::DEN_W-1:0]  denom,
   output logic [drg_pkg::QUO_W-1:0]  quot,
   output logic                       done
);
   import drg_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quot_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [DEN_W:0]    shifted;
   logic              take;

   assign shifted = {rem_ff, low_ff[QUO_W-1]};
   assign take    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer[NUM_W-1:QUO_W];
         low_ff  <= numer[QUO_W-1:0];
         den_ff  <= denom;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= take ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         low_ff  <= {low_ff[QUO_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUO_W-2:0], take};
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

@@ hdl/distance_rolloff_gain_core.sv @@
// distance rolloff gain top level: curve memory, lookup sequencer and gain math
// A write item stores one curve point and gives no result.
// An evaluate item runs these steps from acceptance to its result: squaring
// of the three distance components on one multiplier, starting and running the
// two-bit-per-step square root unit, a read of each curve end point, a read and
// a check state per binary search step (up to four steps for 16 points), setup
// and the one-bit-per-step divider when the distance falls between points, and
// gain multiplication and result load.
// One item is worked on at a time; the result register lets the next item in
// while the previous result waits.  With rolloff disabled an evaluate is taken
// and gives nothing.
module distance_rolloff_gain_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [drg_pkg::IDX_W-1:0]         req_point_index,
   input  logic [drg_pkg::DIST_W-1:0]        req_point_distance,
   input  logic [drg_pkg::GAIN_W-1:0]        req_point_gain,
   input  logic signed [drg_pkg::POS_W-1:0]  req_source_x,
   input  logic signed [drg_pkg::POS_W-1:0]  req_source_y,
   input  logic signed [drg_pkg::POS_W-1:0]  req_source_z,
   input  logic signed [drg_pkg::POS_W-1:0]  req_listener_x,
   input  logic signed [drg_pkg::POS_W-1:0]  req_listener_y,
   input  logic signed [drg_pkg::POS_W-1:0]  req_listener_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [drg_pkg::GAIN_W-1:0]        rsp_gain_flat,
   output logic [drg_pkg::GAIN_W-1:0]        rsp_gain_spatial,
   output logic [drg_pkg::GAIN_W-1:0]        rsp_attenuation,
   output logic [drg_pkg::DIST_W-1:0]        rsp_distance_out,
   input  logic                              csr_we,
   input  logic [drg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [drg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import drg_pkg::*;

   localparam int ENT_W = DIST_W + GAIN_W;

   // configuration
   logic              rolloff_on_ff;
   logic [15:0]       volume_ff;
   logic [15:0]       blend_ff;
   logic [CNT_W-1:0]  points_ff;

   // curve memory
   logic [ENT_W-1:0]  curve_mem [MAX_POINTS];
   logic [ENT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [DIST_W-1:0] rd_dist;
   logic [GAIN_W-1:0] rd_gain;

   state_type         state_ff;
   state_type         state_in;

   logic [1:0]        sq_cnt_ff;
   logic [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [RAD_W-1:0]  acc_ff;
   logic [DIFF_W-1:0] dsel;
   logic [GAIN_W-1:0] w2_ff, w3_ff;
   logic [DIST_W-1:0] d_ff;
   logic [IDX_W-1:0]  lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0]  mid;
   logic [DIST_W-1:0] da_ff, db_ff;
   logic [GAIN_W-1:0] ga_ff, gb_ff;
   logic [DIST_W-1:0] off_ff, span_ff;
   logic [GAIN_W-1:0] mag_ff;
   logic              up_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [GAIN_W-1:0] att_ff;
   logic [31:0]       pflat_ff;
   logic [31:0]       pvw_ff;
   logic [47:0]       psp_ff;
   logic [GAIN_W-1:0] att_div;
   logic [GAIN_W:0]   att_sum;

   logic [CNT_W-1:0]  n_pts;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  new_lo, new_hi;
   logic              srch_le;

   logic              req_fire;
   logic              rsp_free;

   logic                 rsp_valid_ff;
   logic [GAIN_W-1:0]    rsp_flat_ff, rsp_spatial_ff, rsp_att_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;

   unit_ctl_type         sqrt_ctl, div_ctl;
   logic [ROOT_W-1:0]    root;
   logic [QUO_W-1:0]     quot;

   logic [DIFF_W-1:0]    ax, ay, az;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign n_pts    = (points_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_ff;
   assign last_idx = IDX_W'(n_pts - 1'b1);
   assign mid      = IDX_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign rd_dist  = rd_data_ff[ENT_W-1:GAIN_W];
   assign rd_gain  = rd_data_ff[GAIN_W-1:0];
   assign srch_le  = rd_dist <= d_ff;
   assign new_lo   = srch_le ? mid_ff : lo_ff;
   assign new_hi   = srch_le ? hi_ff : mid_ff;

   assign ax = abs_diff(req_source_x, req_listener_x);
   assign ay = abs_diff(req_source_y, req_listener_y);
   assign az = abs_diff(req_source_z, req_listener_z);

   always_comb begin
      case (sq_cnt_ff)
         2'd0:    dsel = dx_ff;
         2'd1:    dsel = dy_ff;
         default: dsel = dz_ff;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rolloff_on_ff <= 1'b0;
         volume_ff     <= UNITY[15:0];
         blend_ff      <= '0;
         points_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROLLOFF_ON: rolloff_on_ff <= csr_data[0];
            CSR_VOLUME:     volume_ff     <= csr_data;
            CSR_BLEND:      blend_ff      <= csr_data;
            CSR_POINTS:     points_ff     <= csr_data[CNT_W-1:0];
            default:        ;
         endcase
      end
   end

   // curve memory
   always_ff @(posedge clock) begin
      if (req_fire && req_type == REQ_WRITE) begin
         curve_mem[req_point_index] <= {req_point_distance, req_point_gain};
      end
      rd_data_ff <= curve_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_type == REQ_EVAL && rolloff_on_ff) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_cnt_ff == 2'd2) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_ctl.done) begin
               state_in = (n_pts == '0) ? ST_MUL1 : ST_LOOK_FIRST;
            end
         end
         ST_LOOK_FIRST: begin
            state_in = (d_ff <= rd_dist) ? ST_MUL1 : ST_LOOK_LAST;
         end
         ST_LOOK_LAST: begin
            if (d_ff >= rd_dist) begin
               state_in = ST_MUL1;
            end else if (last_idx > IDX_W'(1)) begin
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_SRCH_RD: state_in = ST_SRCH_CHK;
         ST_SRCH_CHK: begin
            state_in = (new_hi - new_lo > IDX_W'(1)) ? ST_SRCH_RD : ST_PREP;
         end
         ST_PREP:   state_in = ST_PROD;
         ST_PROD:   state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_ctl.done) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      rd_addr        = '0;
      sqrt_ctl.start = 1'b0;
      div_ctl.start  = 1'b0;
      case (state_ff)
         ST_LOOK_FIRST: rd_addr = last_idx;
         ST_SRCH_RD:    rd_addr = mid;
         ST_ROOT_GO:    sqrt_ctl.start = 1'b1;
         ST_DIV_GO:     div_ctl.start = 1'b1;
         default:       ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // interpolated gain from the divider
   always_comb begin
      att_sum = {1'b0, ga_ff} + quot;
      if (up_ff) begin
         att_div = sat_unity(att_sum);
      end else if (quot > QUO_W'(ga_ff)) begin
         att_div = '0;
      end else begin
         att_div = sat_unity(QUO_W'(ga_ff) - quot);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            dx_ff     <= ax;
            dy_ff     <= ay;
            dz_ff     <= az;
            acc_ff    <= '0;
            sq_cnt_ff <= '0;
            w3_ff     <= quarter_sine({1'b0, blend_ff});
            w2_ff     <= quarter_sine(17'h10000 - {1'b0, blend_ff});
         end
         ST_SQUARE: begin
            acc_ff    <= acc_ff + RAD_W'(dsel) * RAD_W'(dsel);
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
         end
         ST_ROOT: begin
            d_ff   <= root[ROOT_W-1] ? DIST_MAX : root[DIST_W-1:0];
            att_ff <= UNITY[GAIN_W-1:0];
         end
         ST_LOOK_FIRST: begin
            att_ff <= sat_unity({1'b0, rd_gain});
            da_ff  <= rd_dist;
            ga_ff  <= rd_gain;
            lo_ff  <= '0;
         end
         ST_LOOK_LAST: begin
            att_ff <= sat_unity({1'b0, rd_gain});
            db_ff  <= rd_dist;
            gb_ff  <= rd_gain;
            hi_ff  <= last_idx;
         end
         ST_SRCH_RD: mid_ff <= mid;
         ST_SRCH_CHK: begin
            lo_ff <= new_lo;
            hi_ff <= new_hi;
            if (srch_le) begin
               da_ff <= rd_dist;
               ga_ff <= rd_gain;
            end else begin
               db_ff <= rd_dist;
               gb_ff <= rd_gain;
            end
         end
         ST_PREP: begin
            off_ff  <= d_ff - da_ff;
            span_ff <= db_ff - da_ff;
            up_ff   <= gb_ff >= ga_ff;
            mag_ff  <= (gb_ff >= ga_ff) ? gb_ff - ga_ff : ga_ff - gb_ff;
         end
         ST_PROD: begin
            num_ff <= ((NUM_W'(mag_ff) * NUM_W'(off_ff)) << 1) + NUM_W'(span_ff);
         end
         ST_DIV: begin
            if (div_ctl.done) begin
               att_ff <= att_div;
            end
         end
         ST_MUL1: begin
            pflat_ff <= 32'(volume_ff) * 32'(w2_ff);
            pvw_ff   <= 32'(volume_ff) * 32'(w3_ff);
         end
         ST_MUL2: psp_ff <= 48'(pvw_ff) * 48'(att_ff);
         default: ;
      endcase
   end

   // result register
   logic [31:0] flat_rnd;
   logic [47:0] sp_rnd;
   assign flat_rnd = (pflat_ff + 32'd16384) >> 15;
   assign sp_rnd   = (psp_ff + 48'(1 << 29)) >> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_flat_ff    <= (flat_rnd > 32'(UNITY)) ? UNITY[GAIN_W-1:0] : flat_rnd[GAIN_W-1:0];
         rsp_spatial_ff <= (sp_rnd > 48'(UNITY)) ? UNITY[GAIN_W-1:0] : sp_rnd[GAIN_W-1:0];
         rsp_att_ff     <= att_ff;
         rsp_dist_ff    <= d_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gain_flat    = rsp_flat_ff;
   assign rsp_gain_spatial = rsp_spatial_ff;
   assign rsp_attenuation  = rsp_att_ff;
   assign rsp_distance_out = rsp_dist_ff;

   drg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_ctl.start),
      .radicand (acc_ff),
      .root     (root),
      .done     (sqrt_ctl.done)
   );

   drg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_ctl.start),
      .numer (num_ff),
      .denom ({span_ff, 1'b0}),
      .quot  (quot),
      .done  (div_ctl.done)
   );

endmodule

@@ tb/sv/distance_rolloff_gain_core_tb.sv @@
// testbench for distance_rolloff_gain_core: curve writes, gain evaluates, self-checking
`timescale 1ns / 100ps

module distance_rolloff_gain_core_tb;
   import drg_pkg::*;

   typedef struct {
      logic [15:0] flat;
      logic [15:0] spatial;
      logic [15:0] atten;
      logic [23:0] distance;
   } gains_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_WRITE;
   logic [IDX_W-1:0] req_point_index = '0;
   logic [DIST_W-1:0] req_point_distance = '0;
   logic [GAIN_W-1:0] req_point_gain = '0;
   logic signed [POS_W-1:0] req_source_x = '0, req_source_y = '0, req_source_z = '0;
   logic signed [POS_W-1:0] req_listener_x = '0, req_listener_y = '0, req_listener_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [GAIN_W-1:0] rsp_gain_flat, rsp_gain_spatial, rsp_attenuation;
   logic [DIST_W-1:0] rsp_distance_out;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROLLOFF_ON;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   distance_rolloff_gain_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of block state
   logic        rolloff_on;
   logic [15:0] volume;
   logic [15:0] blend;
   logic [4:0]  points_used;
   logic [23:0] pt_dist [MAX_POINTS];
   logic [15:0] pt_gain [MAX_POINTS];

   localparam int SINE_REF [33] = '{
      0, 1608, 3212, 4808, 6393, 7962, 9512, 11039, 12540,
      14010, 15447, 16846, 18205, 19520, 20788, 22006, 23170,
      24279, 25330, 26320, 27246, 28106, 28899, 29622, 30274,
      30853, 31357, 31786, 32138, 32413, 32610, 32729, 32768};

   gains_type expected_gains [$];
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic longint blend_weight(input longint x);
      longint idx, frac, a, b;
      idx = x >> 11;
      frac = x & 2047;
      if (idx >= 32) return 32768;
      a = SINE_REF[idx];
      b = SINE_REF[idx + 1];
      return a + (((b - a) * frac + 1024) >>> 11);
   endfunction

   function automatic longint clip_unity(input longint v);
      return (v > 32768) ? 32768 : v;
   endfunction

   function automatic longint curve_gain_at(input longint d);
      longint n, lo, hi, mid, span, off, ga, gb, mag, q;
      n = (points_used > MAX_POINTS) ? MAX_POINTS : points_used;
      if (n == 0) return 32768;
      if (d <= pt_dist[0]) return clip_unity(pt_gain[0]);
      if (d >= pt_dist[n-1]) return clip_unity(pt_gain[n-1]);
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (pt_dist[mid] <= d) lo = mid;
         else hi = mid;
      end
      span = pt_dist[hi] - pt_dist[lo];
      off = d - pt_dist[lo];
      ga = pt_gain[lo];
      gb = pt_gain[hi];
      mag = (gb >= ga) ? gb - ga : ga - gb;
      q = (2 * mag * off + span) / (2 * span);
      if (gb >= ga) return clip_unity(ga + q);
      return (q > ga) ? 0 : clip_unity(ga - q);
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned sq_delta(input logic signed [23:0] a,
                                                input logic signed [23:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROLLOFF_ON: rolloff_on = value[0];
         CSR_VOLUME:     volume = value[15:0];
         CSR_BLEND:      blend = value[15:0];
         CSR_POINTS:     points_used = value[4:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic typ, input logic [3:0] idx, input logic [23:0] pd,
                            input logic [15:0] pg, input logic signed [23:0] sx,
                            input logic signed [23:0] sy, input logic signed [23:0] sz,
                            input logic signed [23:0] lx, input logic signed [23:0] ly,
                            input logic signed [23:0] lz);
      gains_type g;
      longint d, att, w2, w3;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_point_index <= idx;
      req_point_distance <= pd;
      req_point_gain <= pg;
      req_source_x <= sx;
      req_source_y <= sy;
      req_source_z <= sz;
      req_listener_x <= lx;
      req_listener_y <= ly;
      req_listener_z <= lz;
      do @(posedge clock); while (!req_ready);
      if (typ == REQ_WRITE) begin
         pt_dist[idx] = pd;
         pt_gain[idx] = pg;
      end else if (rolloff_on) begin
         d = root_floor(sq_delta(sx, lx) + sq_delta(sy, ly) + sq_delta(sz, lz));
         if (d > 24'hFFFFFF) d = 24'hFFFFFF;
         att = curve_gain_at(d);
         w3 = blend_weight(blend);
         w2 = blend_weight(65536 - longint'(blend));
         g.flat = 16'(clip_unity((longint'(volume) * w2 + 16384) >> 15));
         g.spatial = 16'(clip_unity((longint'(volume) * w3 * att + (64'd1 << 29)) >> 30));
         g.atten = 16'(att);
         g.distance = 24'(d);
         expected_gains = {expected_gains, g};
      end
   endtask

   task automatic put_point(input int idx, input int pd, input int pg);
      send_item(REQ_WRITE, 4'(idx), 24'(pd), 16'(pg), '0, '0, '0, '0, '0, '0);
   endtask

   task automatic eval_at(input int sx, input int sy, input int sz,
                          input int lx, input int ly, input int lz);
      send_item(REQ_EVAL, 4'($urandom), 24'($urandom), 16'($urandom), 24'(sx), 24'(sy),
                24'(sz), 24'(lx), 24'(ly), 24'(lz));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_gains.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic int rand_pos(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // results compared against oldest expectation
   always @(posedge clock) begin
      gains_type g;
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_gains.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            g = expected_gains.pop_front();
            if (rsp_gain_flat !== g.flat || rsp_gain_spatial !== g.spatial ||
                rsp_attenuation !== g.atten || rsp_distance_out !== g.distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           g.flat, g.spatial, g.atten, g.distance, rsp_gain_flat,
                           rsp_gain_spatial, rsp_attenuation, rsp_distance_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("distance_rolloff_gain_core_tb: done, errors");
         $finish;
      end
   end

   task automatic test_directed;
      write_reg(CSR_ROLLOFF_ON, 1);
      eval_at(0, 0, 0, 0, 0, 0);
      eval_at(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
      put_point(0, 256, 32768);
      put_point(1, 2560, 16384);
      put_point(2, 25600, 0);
      put_point(3, 16777215, 65535);
      put_point(15, 0, 0);
      drain();
      write_reg(CSR_POINTS, 3);
      eval_at(0, 0, 0, 100, 0, 0);
      eval_at(0, 0, 0, 1000, 0, 0);
      eval_at(0, 0, 0, 2560, 0, 0);
      eval_at(300, 400, 0, 0, 0, 0);
      eval_at(0, 0, 0, 0, 30000, 0);
      drain();
      write_reg(CSR_POINTS, 4);
      write_reg(CSR_VOLUME, 65535);
      write_reg(CSR_BLEND, 65535);
      eval_at(8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
      eval_at(0, 0, 0, 0, 0, 20000);
      drain();
      write_reg(CSR_BLEND, 32768);
      write_reg(CSR_VOLUME, 0);
      eval_at(1, 2, 3, 4, 5, 6);
      drain();
      write_reg(CSR_VOLUME, 32768);
      put_point(1, 100, 40000);
      put_point(2, 50, 1000);
      eval_at(0, 0, 0, 80, 0, 0);
      eval_at(0, 0, 0, 30000, 0, 0);
      drain();
      write_reg(CSR_ROLLOFF_ON, 0);
      eval_at(0, 0, 0, 80, 0, 0);
      drain();
   endtask

   task automatic test_random(input int count);
      int n, base, step, span;
      n = $urandom_range(16);
      for (int i = 0; i < MAX_POINTS; i++) begin
         base = (i == 0) ? $urandom_range(255) : base + step;
         step = $urandom_range(1, 4000);
         if ($urandom_range(9) == 0) base = $urandom;
         put_point(i, base & 24'hFFFFFF, ($urandom_range(9) == 0) ? $urandom : $urandom_range(32768));
      end
      write_reg(CSR_ROLLOFF_ON, ($urandom_range(9) != 0));
      write_reg(CSR_VOLUME, ($urandom_range(7) == 0) ? $urandom : $urandom_range(32768));
      write_reg(CSR_BLEND, $urandom);
      write_reg(CSR_POINTS, ($urandom_range(9) == 0) ? 16 + $urandom_range(15) : n);
      for (int i = 0; i < count; i++) begin
         span = ($urandom_range(3) == 0) ? 8388607 : 40000;
         if ($urandom_range(9) == 0) put_point($urandom, $urandom, $urandom);
         else eval_at(rand_pos(span), rand_pos(span), rand_pos(span),
                      rand_pos(span), rand_pos(span), rand_pos(span));
      end
      drain();
   endtask

   task automatic test_idle_phases;
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(325);
      send_idle_pct = 85; recv_stall_pct = 0;  test_random(325);
      send_idle_pct = 0;  recv_stall_pct = 85; test_random(325);
      send_idle_pct = 19; recv_stall_pct = 19; test_random(325);
   endtask

   initial begin
      rolloff_on = 0;
      volume = 16'd32768;
      blend = 0;
      points_used = 0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         pt_dist[i] = 0;
         pt_gain[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_idle_phases();
      if (mismatches == 0 && expected_gains.size() == 0)
         $display("distance_rolloff_gain_core_tb: done, clean");
      else
         $display("distance_rolloff_gain_core_tb: done, errors");
      $finish;
   end

endmodule
